[rtl/drst_pkg.sv]
// Package for the dirty-rectangle slot tracker: sizes, command and status codes,
// box type, controller states and the controller/datapath command structs.
// No dependencies; the controller, datapath, top level and bench import it.
`timescale 1ns / 1ps
`default_nettype none

package drst_pkg;

    // Slots per bank, and the derived index and memory widths
    localparam int SLOTS     = 16;
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MEM_AW    = SLOT_W + 1;
    localparam int MEM_DEPTH = 1 << MEM_AW;
    // allocate only looks at slots that the 4-bit slot field can name
    localparam int ALLOC_N   = (SLOTS < 16) ? SLOTS : 16;

    localparam logic [15:0] BOX_EMPTY_MIN = 16'h03FC;
    localparam logic [15:0] BOX_EMPTY_MAX = 16'd2;
    localparam logic [15:0] PAD           = 16'd2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [2:0] {
        CMD_ADD        = 3'd0,
        CMD_ALLOC      = 3'd1,
        CMD_RELEASE    = 3'd2,
        CMD_NEW_FRAME  = 3'd3,
        CMD_QUERY_CUR  = 3'd4,
        CMD_QUERY_PREV = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_NONE = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_WIDTH  = 2'd0,
        CFG_SCREEN_HEIGHT = 2'd1,
        CFG_ACTIVE_BANK   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] right;
        logic [15:0] bottom;
    } t_box;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_NF_RD,
        S_NF_WR,
        S_FINISH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch the input item and read its slot
        logic commit;    // apply the command and load the result register
        logic nf_init;   // clear the new-frame sweep counter
        logic nf_rd;     // read the slot under the sweep counter
        logic nf_wr;     // write back that slot and advance
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic new_frame;
        logic nf_last;
    } t_dp_stat;

endpackage

`default_nettype wire

[rtl/drst_req_if.sv]
// Request channel of the slot tracker: valid/ready handshake and command payload.
// Field widths are fixed by the command format; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface drst_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [3:0]  slot;
    logic [15:0] in_left;
    logic [15:0] in_top;
    logic [15:0] in_right;
    logic [15:0] in_bottom;

    modport source (
        output valid, command, slot, in_left, in_top, in_right, in_bottom,
        input  ready
    );
    modport sink (
        input  valid, command, slot, in_left, in_top, in_right, in_bottom,
        output ready
    );
endinterface

`default_nettype wire

[rtl/drst_rsp_if.sv]
// Response channel of the slot tracker: valid/ready handshake and result payload.
// Field widths are fixed by the result format; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

interface drst_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [3:0]  granted_slot;
    logic [15:0] box_left;
    logic [15:0] box_top;
    logic [15:0] box_right;
    logic [15:0] box_bottom;

    modport source (
        output valid, status, granted_slot, box_left, box_top, box_right, box_bottom,
        input  ready
    );
    modport sink (
        input  valid, status, granted_slot, box_left, box_top, box_right, box_bottom,
        output ready
    );
endinterface

`default_nettype wire

[rtl/drst_ctrl.sv]
// Controller of the slot tracker: sequences capture, execute, the new-frame sweep
// and the result register handshake. Depends on drst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module drst_ctrl
    import drst_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_out_ready,
    input  wire t_dp_stat i_stat,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output t_dp_cmd       o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        out_free   = !r_out_valid || i_out_ready;
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.new_frame) begin
                    o_cmd.nf_init = 1'b1;
                    n_state       = S_NF_RD;
                end else if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_NF_RD: begin
                o_cmd.nf_rd = 1'b1;
                n_state     = S_NF_WR;
            end
            S_NF_WR: begin
                o_cmd.nf_wr = 1'b1;
                n_state     = i_stat.nf_last ? S_FINISH : S_NF_RD;
            end
            S_FINISH: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[rtl/drst_dpath.sv]
// Datapath of the slot tracker: configuration registers, slot valid/dirty flags,
// box memories, padding and growth logic, result register. Depends on drst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module drst_dpath
    import drst_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_stat                   o_stat,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic [2:0]            i_command,
    input  wire logic [3:0]            i_slot,
    input  wire logic [15:0]           i_in_left,
    input  wire logic [15:0]           i_in_top,
    input  wire logic [15:0]           i_in_right,
    input  wire logic [15:0]           i_in_bottom,
    output logic [1:0]                 o_status,
    output logic [3:0]                 o_granted_slot,
    output logic [15:0]                o_box_left,
    output logic [15:0]                o_box_top,
    output logic [15:0]                o_box_right,
    output logic [15:0]                o_box_bottom
);

    localparam t_box EMPTY_BOX  = '{BOX_EMPTY_MIN, BOX_EMPTY_MIN, BOX_EMPTY_MAX, BOX_EMPTY_MAX};
    localparam t_box ALLOC_PREV = '{BOX_EMPTY_MIN, BOX_EMPTY_MAX, BOX_EMPTY_MAX, BOX_EMPTY_MAX};

    function automatic logic [15:0] pad_min(input logic [15:0] v);
        logic [15:0] d;
        d = (v >= PAD) ? v - PAD : v;
        return {d[15:1], 1'b0};
    endfunction

    // raise by the pad if it stays on screen, then round up to even, saturating
    function automatic logic [15:0] pad_max(input logic [15:0] v, input logic [15:0] lim);
        logic [15:0] u;
        u = (v <= lim) ? v + PAD : v;
        if (u[0] && (u != 16'hFFFF)) begin
            u = u + 16'd1;
        end
        return u;
    endfunction

    // configuration
    logic [15:0] r_screen_w, r_screen_h;
    logic        r_bank;
    logic [15:0] lim_w, lim_h;

    // captured item
    logic [2:0]        r_cmd;
    logic              r_slot_ok;
    logic [SLOT_W-1:0] r_idx;
    logic              r_empty_span;
    t_box              r_pad;
    logic              slot_ok_in;
    logic [SLOT_W-1:0] idx_in;

    // slot flags and box storage
    logic [SLOTS-1:0]  r_valid [2];
    logic [SLOTS-1:0]  r_dirty [2];
    t_box              r_cur_mem  [MEM_DEPTH];
    t_box              r_prev_mem [MEM_DEPTH];
    t_box              r_cur_rd, r_prev_rd;
    logic              rd_en;
    logic [MEM_AW-1:0] rd_addr;

    logic [SLOT_W-1:0] r_nf_cnt;

    // execute
    logic              cur_we, prev_we;
    logic [SLOT_W-1:0] wr_idx;
    t_box              cur_wdata, prev_wdata;
    logic              v_set, v_clr, d_set, d_clr;
    logic              slot_valid, slot_dirty;
    logic              free_found;
    logic [SLOT_W-1:0] free_idx;
    t_box              grown;
    logic              grew;
    logic [1:0]        n_status;
    logic [3:0]        n_granted;
    t_box              n_box;

    // result register
    logic [1:0] r_status;
    logic [3:0] r_granted;
    t_box       r_box;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_w <= 16'd640;
            r_screen_h <= 16'd480;
            r_bank     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SCREEN_WIDTH:  r_screen_w <= i_cfg_wdata;
                CFG_SCREEN_HEIGHT: r_screen_h <= i_cfg_wdata;
                CFG_ACTIVE_BANK:   r_bank     <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign lim_w      = (r_screen_w < PAD) ? '0 : r_screen_w - PAD;
    assign lim_h      = (r_screen_h < PAD) ? '0 : r_screen_h - PAD;
    assign slot_ok_in = ({28'd0, i_slot} < 32'(SLOTS));
    assign idx_in     = SLOT_W'(i_slot);

    // capture the item with its padded span
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd        <= i_command;
            r_slot_ok    <= slot_ok_in;
            r_idx        <= idx_in;
            r_empty_span <= (i_in_right <= i_in_left);
            r_pad.left   <= pad_min(i_in_left);
            r_pad.top    <= pad_min(i_in_top);
            r_pad.right  <= pad_max(i_in_right, lim_w);
            r_pad.bottom <= pad_max(i_in_bottom, lim_h);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nf_cnt <= '0;
        end else if (i_cmd.nf_init) begin
            r_nf_cnt <= '0;
        end else if (i_cmd.nf_wr) begin
            r_nf_cnt <= r_nf_cnt + 1'b1;
        end
    end

    assign rd_en   = i_cmd.capture || i_cmd.nf_rd;
    assign rd_addr = i_cmd.capture ? {r_bank, idx_in} : {r_bank, r_nf_cnt};

    always_ff @(posedge i_clk) begin
        if (cur_we) begin
            r_cur_mem[{r_bank, wr_idx}] <= cur_wdata;
        end
        if (prev_we) begin
            r_prev_mem[{r_bank, wr_idx}] <= prev_wdata;
        end
        if (rd_en) begin
            r_cur_rd  <= r_cur_mem[rd_addr];
            r_prev_rd <= r_prev_mem[rd_addr];
        end
    end

    assign slot_valid = r_slot_ok && r_valid[r_bank][r_idx];
    assign slot_dirty = r_dirty[r_bank][r_idx];

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = ALLOC_N - 1; i >= 0; i--) begin
            if (!r_valid[r_bank][i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        grown.left   = (r_pad.left   < r_cur_rd.left)   ? r_pad.left   : r_cur_rd.left;
        grown.top    = (r_pad.top    < r_cur_rd.top)    ? r_pad.top    : r_cur_rd.top;
        grown.right  = (r_pad.right  > r_cur_rd.right)  ? r_pad.right  : r_cur_rd.right;
        grown.bottom = (r_pad.bottom > r_cur_rd.bottom) ? r_pad.bottom : r_cur_rd.bottom;
        grew = (r_pad.left < r_cur_rd.left) || (r_pad.top < r_cur_rd.top) ||
               (r_pad.right > r_cur_rd.right) || (r_pad.bottom > r_cur_rd.bottom);
    end

    always_comb begin
        cur_we     = 1'b0;
        prev_we    = 1'b0;
        wr_idx     = r_idx;
        cur_wdata  = EMPTY_BOX;
        prev_wdata = ALLOC_PREV;
        v_set      = 1'b0;
        v_clr      = 1'b0;
        d_set      = 1'b0;
        d_clr      = 1'b0;
        n_status   = ST_NONE;
        n_granted  = '0;
        n_box      = '0;

        if (i_cmd.nf_wr) begin
            // roll the current box into previous and restart it
            wr_idx = r_nf_cnt;
            if (r_valid[r_bank][r_nf_cnt]) begin
                cur_we     = 1'b1;
                prev_we    = 1'b1;
                prev_wdata = r_cur_rd;
                d_clr      = 1'b1;
            end
        end else if (i_cmd.commit) begin
            case (r_cmd)
                CMD_ADD: begin
                    if (slot_valid && !r_empty_span) begin
                        n_status  = ST_OK;
                        cur_we    = grew;
                        cur_wdata = grown;
                        d_set     = grew;
                    end
                end
                CMD_ALLOC: begin
                    if (free_found) begin
                        n_status  = ST_OK;
                        n_granted = 4'(free_idx);
                        wr_idx    = free_idx;
                        cur_we    = 1'b1;
                        prev_we   = 1'b1;
                        v_set     = 1'b1;
                        d_clr     = 1'b1;
                    end else begin
                        n_status = ST_FULL;
                    end
                end
                CMD_RELEASE: begin
                    if (slot_valid) begin
                        n_status = ST_OK;
                        v_clr    = 1'b1;
                    end
                end
                CMD_NEW_FRAME: begin
                    n_status = ST_OK;
                end
                CMD_QUERY_CUR: begin
                    if (slot_valid && slot_dirty) begin
                        n_status = ST_OK;
                        n_box    = r_cur_rd;
                    end
                end
                CMD_QUERY_PREV: begin
                    if (slot_valid && (r_prev_rd.left <= r_prev_rd.right)) begin
                        n_status = ST_OK;
                        n_box    = r_prev_rd;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '{default: '0};
            r_dirty <= '{default: '0};
        end else begin
            if (v_set) begin
                r_valid[r_bank][wr_idx] <= 1'b1;
            end else if (v_clr) begin
                r_valid[r_bank][wr_idx] <= 1'b0;
            end
            if (d_set) begin
                r_dirty[r_bank][wr_idx] <= 1'b1;
            end else if (d_clr) begin
                r_dirty[r_bank][wr_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status  <= n_status;
            r_granted <= n_granted;
            r_box     <= n_box;
        end
    end

    assign o_stat.new_frame = (r_cmd == CMD_NEW_FRAME);
    assign o_stat.nf_last   = (r_nf_cnt == SLOT_W'(SLOTS - 1));

    assign o_status       = r_status;
    assign o_granted_slot = r_granted;
    assign o_box_left     = r_box.left;
    assign o_box_top      = r_box.top;
    assign o_box_right    = r_box.right;
    assign o_box_bottom   = r_box.bottom;

endmodule

`default_nettype wire

[rtl/dirty_rect_slot_tracker_top.sv]
// Dirty-rectangle slot tracker, top level. Add, allocate, release and queries capture the
// request, then load the result register from the execute state; no new request transfers
// until then, and a result stalled downstream holds the command until the result register frees.
// New-frame sweeps the bank slot by slot (read, then write back each box memory), then loads
// the result from the finish state. Reset (synchronous,
// active low) frees every slot, clears dirty marks, sets 640x480, bank 0. Needs drst_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dirty_rect_slot_tracker_top
    import drst_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    drst_req_if.sink                   i_req,
    drst_rsp_if.source                 o_rsp,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Controller: one request at a time; the result register lets the next
    // request transfer while the previous result still waits downstream.
    drst_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .i_stat      (dp_stat),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (dp_cmd)
    );

    // Datapath: slot flags, box memories of both banks, padding and growth.
    drst_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_command      (i_req.command),
        .i_slot         (i_req.slot),
        .i_in_left      (i_req.in_left),
        .i_in_top       (i_req.in_top),
        .i_in_right     (i_req.in_right),
        .i_in_bottom    (i_req.in_bottom),
        .o_status       (o_rsp.status),
        .o_granted_slot (o_rsp.granted_slot),
        .o_box_left     (o_rsp.box_left),
        .o_box_top      (o_rsp.box_top),
        .o_box_right    (o_rsp.box_right),
        .o_box_bottom   (o_rsp.box_bottom)
    );

endmodule

`default_nettype wire

[tb/tb_top.sv]
// Self-checking bench for the dirty-rectangle slot tracker: a command driver, a reply monitor
// and a bit-exact tracker predictor, run through several screen and bank settings.
// Depends on drst_pkg, drst_req_if, drst_rsp_if and dirty_rect_slot_tracker_top.
`timescale 1ns / 1ps

module tb_top;
    import drst_pkg::*;

    // Run limit, far above the slowest legal run with every long stall
    localparam int CYCLE_LIMIT = 1000000;
    // Quiet time after the last reply
    localparam int DRAIN_CYCLES = 2 * SLOTS + 8;

    // The two codes the command field can carry that the block does not define
    localparam logic [2:0] CMD_RSVD_6 = 3'd6;
    localparam logic [2:0] CMD_RSVD_7 = 3'd7;

    typedef struct packed {
        logic [2:0] command;
        logic [3:0] slot;
        t_box       span;
    } tracker_cmd_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] granted;
        t_box       box;
    } tracker_reply_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    drst_req_if req_ch ();
    drst_rsp_if rsp_ch ();

    dirty_rect_slot_tracker_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Tracker shadow: configuration and both banks of slots
    // ------------------------------------------------------------------
    logic [15:0] scr_w;
    logic [15:0] scr_h;
    logic        bank_sel;
    logic        slot_used  [2][SLOTS];
    logic        slot_dirty [2][SLOTS];
    t_box        cur_box    [2][SLOTS];
    t_box        prev_box   [2][SLOTS];

    tracker_cmd_t   command_q [$];
    tracker_reply_t reply_q   [$];

    logic req_taken = 1'b0;
    int   gap_left = 0;
    int   stall_left = 0;
    bit   idle_en = 1'b1;
    int   mismatches = 0;
    int   cycle_count = 0;

    // Lower a min edge by the pad unless it would go below zero, then round down to even
    function automatic int unsigned pad_low(int unsigned v);
        int unsigned x;
        x = (v >= 2) ? v - 2 : v;
        return x & ~32'd1;
    endfunction

    // Raise a max edge by the pad while it stays on screen, then round up to even
    // without running past the 16-bit range
    function automatic int unsigned pad_high(int unsigned v, int unsigned dim);
        int unsigned lim;
        int unsigned x;
        lim = (dim < 2) ? 0 : dim - 2;
        x = v;
        if (x <= lim)
            x = x + 2;
        if (x[0])
            x = (x >= 32'hFFFF) ? 32'hFFFF : x + 1;
        return x;
    endfunction

    function automatic t_box empty_box();
        t_box bx;
        bx.left   = BOX_EMPTY_MIN;
        bx.top    = BOX_EMPTY_MIN;
        bx.right  = BOX_EMPTY_MAX;
        bx.bottom = BOX_EMPTY_MAX;
        return bx;
    endfunction

    // Apply one command to the shadow banks and return the reply it must produce
    function automatic tracker_reply_t track_command(tracker_cmd_t it);
        tracker_reply_t rep;
        t_box           c;
        int unsigned    nl, nt, nr, nb;
        logic           bk;
        bit             hit;
        bit             in_range;
        rep      = '0;
        rep.status = ST_NONE;
        bk       = bank_sel;
        hit      = 1'b0;
        in_range = (it.slot < SLOTS);
        case (it.command)
            CMD_ADD: begin
                // empty spans are judged by the horizontal edges only
                if (it.span.right > it.span.left && in_range && slot_used[bk][it.slot]) begin
                    c  = cur_box[bk][it.slot];
                    nl = pad_low(it.span.left);
                    nt = pad_low(it.span.top);
                    nr = pad_high(it.span.right, scr_w);
                    nb = pad_high(it.span.bottom, scr_h);
                    if (nl < c.left) begin
                        c.left = nl[15:0];
                        slot_dirty[bk][it.slot] = 1'b1;
                    end
                    if (nt < c.top) begin
                        c.top = nt[15:0];
                        slot_dirty[bk][it.slot] = 1'b1;
                    end
                    if (nr > c.right) begin
                        c.right = nr[15:0];
                        slot_dirty[bk][it.slot] = 1'b1;
                    end
                    if (nb > c.bottom) begin
                        c.bottom = nb[15:0];
                        slot_dirty[bk][it.slot] = 1'b1;
                    end
                    cur_box[bk][it.slot] = c;
                    rep.status = ST_OK;
                end
            end
            CMD_ALLOC: begin
                rep.status = ST_FULL;
                for (int i = 0; i < SLOTS && i < 16; i++) begin
                    if (!hit && !slot_used[bk][i]) begin
                        hit = 1'b1;
                        slot_used[bk][i]       = 1'b1;
                        slot_dirty[bk][i]      = 1'b0;
                        cur_box[bk][i]         = empty_box();
                        prev_box[bk][i].left   = BOX_EMPTY_MIN;
                        prev_box[bk][i].top    = BOX_EMPTY_MAX;
                        prev_box[bk][i].right  = BOX_EMPTY_MAX;
                        prev_box[bk][i].bottom = BOX_EMPTY_MAX;
                        rep.granted = i[3:0];
                        rep.status  = ST_OK;
                    end
                end
            end
            CMD_RELEASE: begin
                if (in_range && slot_used[bk][it.slot]) begin
                    slot_used[bk][it.slot] = 1'b0;
                    rep.status = ST_OK;
                end
            end
            CMD_NEW_FRAME: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_used[bk][i]) begin
                        slot_dirty[bk][i] = 1'b0;
                        prev_box[bk][i]   = cur_box[bk][i];
                        cur_box[bk][i]    = empty_box();
                    end
                end
                rep.status = ST_OK;
            end
            CMD_QUERY_CUR: begin
                if (in_range && slot_used[bk][it.slot] && slot_dirty[bk][it.slot]) begin
                    rep.box    = cur_box[bk][it.slot];
                    rep.status = ST_OK;
                end
            end
            CMD_QUERY_PREV: begin
                if (in_range && slot_used[bk][it.slot]
                        && prev_box[bk][it.slot].left <= prev_box[bk][it.slot].right) begin
                    rep.box    = prev_box[bk][it.slot];
                    rep.status = ST_OK;
                end
            end
            default: ;
        endcase
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, int unsigned got, int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // Monitor: compare each reply transfer with the oldest prediction, then predict
    // the command transfer of the same edge. A reply never shares an edge with its
    // own command, so the order inside this block does not matter.
    always @(posedge i_clk) begin
        tracker_cmd_t   seen;
        tracker_reply_t want;
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (reply_q.size() == 0) begin
                    report_mismatch("reply with no command outstanding");
                end else begin
                    want = reply_q.pop_front();
                    check_field("status", rsp_ch.status, want.status);
                    check_field("granted_slot", rsp_ch.granted_slot, want.granted);
                    check_field("box_left", rsp_ch.box_left, want.box.left);
                    check_field("box_top", rsp_ch.box_top, want.box.top);
                    check_field("box_right", rsp_ch.box_right, want.box.right);
                    check_field("box_bottom", rsp_ch.box_bottom, want.box.bottom);
                end
            end
            if (req_ch.valid && req_ch.ready) begin
                seen.command     = req_ch.command;
                seen.slot        = req_ch.slot;
                seen.span.left   = req_ch.in_left;
                seen.span.top    = req_ch.in_top;
                seen.span.right  = req_ch.in_right;
                seen.span.bottom = req_ch.in_bottom;
                reply_q.push_back(track_command(seen));
            end
        end
        // tell the driver on its falling edge whether its item went through
        req_taken <= i_rst_n && req_ch.valid && req_ch.ready;
    end

    // Timeout guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Idle lengths: mostly none, some short, a few long
    // ------------------------------------------------------------------
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_en || r < 65)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Command driver: hold an item until it transfers, then sit out its gap and
    // present the next one. Everything changes on the falling edge.
    always @(negedge i_clk) begin
        tracker_cmd_t nxt;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_taken) begin
            if (gap_left != 0) begin
                req_ch.valid <= 1'b0;
                gap_left     <= gap_left - 1;
            end else if (command_q.size() != 0) begin
                nxt = command_q.pop_front();
                req_ch.command   <= nxt.command;
                req_ch.slot      <= nxt.slot;
                req_ch.in_left   <= nxt.span.left;
                req_ch.in_top    <= nxt.span.top;
                req_ch.in_right  <= nxt.span.right;
                req_ch.in_bottom <= nxt.span.bottom;
                req_ch.valid     <= 1'b1;
                gap_left         <= idle_len();
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Reply sink: random back-pressure stretches
    always @(negedge i_clk) begin
        int n;
        if (stall_left != 0) begin
            rsp_ch.ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end else begin
            n = idle_len();
            rsp_ch.ready <= (n == 0);
            stall_left   <= (n == 0) ? 0 : n - 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic tracker_cmd_t make_cmd(logic [2:0] cmd, logic [3:0] slot,
                                              logic [15:0] l, logic [15:0] t,
                                              logic [15:0] r, logic [15:0] b);
        tracker_cmd_t it;
        it.command     = cmd;
        it.slot        = slot;
        it.span.left   = l;
        it.span.top    = t;
        it.span.right  = r;
        it.span.bottom = b;
        return it;
    endfunction

    // Coordinates cluster on the screen and its edges, with some full-range noise
    function automatic logic [15:0] pick_coord(int dim);
        int d;
        int hi;
        d = (dim < 2) ? 2 : dim;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                hi = (d + 4 > 65535) ? 65535 : d + 4;
                return 16'($urandom_range(0, hi));
            end
            5, 6:    return 16'($urandom);
            7:       return 16'($urandom_range(0, 3));
            8: begin
                hi = (d + 1 > 65535) ? 65535 : d + 1;
                return 16'($urandom_range(d - 2, hi));
            end
            default: return 16'($urandom_range(65532, 65535));
        endcase
    endfunction

    // One random command; 'heavy' leans on allocate so the table fills up
    function automatic tracker_cmd_t random_cmd(int w, int h, bit heavy);
        tracker_cmd_t it;
        logic [15:0]  tmp;
        int           r;
        r = $urandom_range(0, 99);
        if (heavy) begin
            if      (r < 30) it.command = CMD_ADD;
            else if (r < 65) it.command = CMD_ALLOC;
            else if (r < 68) it.command = CMD_RELEASE;
            else if (r < 72) it.command = CMD_NEW_FRAME;
            else if (r < 84) it.command = CMD_QUERY_CUR;
            else if (r < 96) it.command = CMD_QUERY_PREV;
            else             it.command = $urandom_range(0, 1) ? CMD_RSVD_6 : CMD_RSVD_7;
        end else begin
            if      (r < 45) it.command = CMD_ADD;
            else if (r < 55) it.command = CMD_ALLOC;
            else if (r < 62) it.command = CMD_RELEASE;
            else if (r < 67) it.command = CMD_NEW_FRAME;
            else if (r < 82) it.command = CMD_QUERY_CUR;
            else if (r < 96) it.command = CMD_QUERY_PREV;
            else             it.command = $urandom_range(0, 1) ? CMD_RSVD_6 : CMD_RSVD_7;
        end
        // low slots are the ones allocate hands out first
        if (heavy || $urandom_range(0, 3) == 0)
            it.slot = 4'($urandom_range(0, 15));
        else
            it.slot = 4'($urandom_range(0, 5));
        it.span.left   = pick_coord(w);
        it.span.top    = pick_coord(h);
        it.span.right  = pick_coord(w);
        it.span.bottom = pick_coord(h);
        // most adds carry a proper span; the rest stay empty or inverted
        if (it.command == CMD_ADD && $urandom_range(0, 9) != 0) begin
            if (it.span.right < it.span.left) begin
                tmp           = it.span.right;
                it.span.right = it.span.left;
                it.span.left  = tmp;
            end
            if (it.span.right == it.span.left) begin
                if (it.span.right != 16'hFFFF)
                    it.span.right = it.span.right + 16'd1;
                else
                    it.span.left = it.span.left - 16'd1;
            end
            if ($urandom_range(0, 1) && it.span.bottom < it.span.top) begin
                tmp            = it.span.bottom;
                it.span.bottom = it.span.top;
                it.span.top    = tmp;
            end
        end
        return it;
    endfunction

    // Block until no command is queued or in flight and no reply is outstanding
    task automatic wait_quiet();
        @(posedge i_clk);
        while (command_q.size() != 0 || req_ch.valid || reply_q.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_SCREEN_WIDTH:  scr_w    = val;
            CFG_SCREEN_HEIGHT: scr_h    = val;
            CFG_ACTIVE_BANK:   bank_sel = val[0];
            default: ;
        endcase
    endtask

    // Drain, retune every register, then queue a batch of random commands
    task automatic run_phase(int w, int h, bit bank, int n, bit heavy, bit calm);
        wait_quiet();
        repeat (4) @(posedge i_clk);
        write_reg(CFG_SCREEN_WIDTH, w[15:0]);
        write_reg(CFG_SCREEN_HEIGHT, h[15:0]);
        write_reg(CFG_ACTIVE_BANK, {15'd0, bank});
        idle_en = !calm;
        for (int k = 0; k < n; k++)
            command_q.push_back(random_cmd(w, h, heavy));
    endtask

    // ------------------------------------------------------------------
    // Sequence of the run
    // ------------------------------------------------------------------
    initial begin
        // known values on every input from time zero
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = CFG_SCREEN_WIDTH;
        i_cfg_wdata      = '0;
        req_ch.valid     = 1'b0;
        req_ch.command   = CMD_ADD;
        req_ch.slot      = '0;
        req_ch.in_left   = '0;
        req_ch.in_top    = '0;
        req_ch.in_right  = '0;
        req_ch.in_bottom = '0;
        rsp_ch.ready     = 1'b0;

        // shadow state after reset
        scr_w    = 16'd640;
        scr_h    = 16'd480;
        bank_sel = 1'b0;
        for (int b = 0; b < 2; b++) begin
            for (int s = 0; s < SLOTS; s++) begin
                slot_used[b][s]  = 1'b0;
                slot_dirty[b][s] = 1'b0;
                cur_box[b][s]    = '0;
                prev_box[b][s]   = '0;
            end
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part at the reset screen size, bank 0
        command_q.push_back(make_cmd(CMD_ALLOC, 0, 0, 0, 0, 0));
        command_q.push_back(make_cmd(CMD_ALLOC, 0, 0, 0, 0, 0));
        // full-range span: min edges cannot drop, max edges saturate at 65535
        command_q.push_back(make_cmd(CMD_ADD, 0, 0, 0, 16'hFFFF, 16'hFFFF));
        // odd edges below the pad: no lowering, rounding only
        command_q.push_back(make_cmd(CMD_ADD, 1, 1, 1, 3, 3));
        // empty span and inverted span are ignored
        command_q.push_back(make_cmd(CMD_ADD, 1, 9, 9, 9, 9));
        command_q.push_back(make_cmd(CMD_ADD, 1, 20, 0, 10, 50));
        // adds to free slots are ignored
        command_q.push_back(make_cmd(CMD_ADD, 5, 10, 10, 20, 20));
        command_q.push_back(make_cmd(CMD_ADD, 15, 10, 10, 20, 20));
        command_q.push_back(make_cmd(CMD_QUERY_CUR, 0, 0, 0, 0, 0));
        command_q.push_back(make_cmd(CMD_QUERY_CUR, 2, 0, 0, 0, 0));
        // previous box straight after allocate reads as no box
        command_q.push_back(make_cmd(CMD_QUERY_PREV, 0, 0, 0, 0, 0));
        command_q.push_back(make_cmd(CMD_NEW_FRAME, 0, 0, 0, 0, 0));
        command_q.push_back(make_cmd(CMD_QUERY_PREV, 0, 0, 0, 0, 0));
        command_q.push_back(make_cmd(CMD_QUERY_CUR, 0, 0, 0, 0, 0));
        // max edges exactly at the screen limit get padded, one past it only rounds
        command_q.push_back(make_cmd(CMD_ADD, 0, 3, 5, 638, 478));
        // same box again: no growth, still ok
        command_q.push_back(make_cmd(CMD_ADD, 0, 3, 5, 639, 479));
        command_q.push_back(make_cmd(CMD_ADD, 1, 100, 200, 101, 201));
        command_q.push_back(make_cmd(CMD_NEW_FRAME, 0, 0, 0, 0, 0));
        command_q.push_back(make_cmd(CMD_RELEASE, 1, 0, 0, 0, 0));
        command_q.push_back(make_cmd(CMD_RELEASE, 1, 0, 0, 0, 0));
        command_q.push_back(make_cmd(CMD_QUERY_PREV, 1, 0, 0, 0, 0));
        command_q.push_back(make_cmd(CMD_RSVD_6, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        command_q.push_back(make_cmd(CMD_RSVD_7, 15, 0, 0, 0, 0));
        command_q.push_back(make_cmd(CMD_QUERY_CUR, 0, 0, 0, 0, 0));
        command_q.push_back(make_cmd(CMD_QUERY_PREV, 0, 0, 0, 0, 0));

        // Random part across several settings, extremes included
        run_phase(65535, 65535, 1'b1, 200, 1'b0, 1'b0);
        run_phase(2, 2, 1'b0, 150, 1'b0, 1'b0);
        // fill bank 1 to the last slot to hit the full table
        run_phase($urandom_range(16, 4095), $urandom_range(16, 4095), 1'b1, 250, 1'b1, 1'b0);
        // dimensions below the pad behave like the smallest screen
        run_phase(1, 0, 1'b0, 100, 1'b0, 1'b0);
        run_phase($urandom_range(2, 65535), $urandom_range(2, 65535), 1'b1, 250, 1'b0, 1'b1);
        run_phase(640, 480, 1'b0, 250, 1'b1, 1'b0);

        // let the last replies in, then give the block time to go quiet
        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
rtl/drst_pkg.sv
rtl/drst_req_if.sv
rtl/drst_rsp_if.sv
rtl/drst_ctrl.sv
rtl/drst_dpath.sv
rtl/dirty_rect_slot_tracker_top.sv
tb/tb_top.sv
